[hw/rtl/sge_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sge_pkg: shared types and constants of the gate engine
// Item kinds, status codes, field widths and the command word that the
// front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package sge_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_WIDTH_DEF  = 18;

    localparam int FRAC_BITS = 16;
    localparam int MAT_W     = 18;
    localparam int RND_W     = 32;
    localparam int QIDX_W    = 4;
    localparam int CFG_W     = 4;
    localparam int OUT_W     = 10;
    localparam int CFG_RESET = 10;

    localparam logic [1:0] KIND_GATE = 2'd0;
    localparam logic [1:0] KIND_CNOT = 2'd1;
    localparam logic [1:0] KIND_MEAS = 2'd2;
    localparam logic [1:0] KIND_INIT = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              status;
        logic [QIDX_W-1:0]       target;
        logic [QIDX_W-1:0]       control;
        logic signed [MAT_W-1:0] m00_re;
        logic signed [MAT_W-1:0] m00_im;
        logic signed [MAT_W-1:0] m01_re;
        logic signed [MAT_W-1:0] m01_im;
        logic signed [MAT_W-1:0] m10_re;
        logic signed [MAT_W-1:0] m10_im;
        logic signed [MAT_W-1:0] m11_re;
        logic signed [MAT_W-1:0] m11_im;
        logic [RND_W-1:0]        rnd;
    } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/sge_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sge_front: input classification
// Checks qubit indexes against the effective qubit count, builds the
// command word and pushes it into the command queue.
// ----------------------------------------------------------------------------
module sge_front #(
    parameter int MAX_QUBITS = sge_pkg::MAX_QUBITS_DEF,
    parameter int NQ_W       = $clog2(MAX_QUBITS + 1)
) (
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_kind,
    input  wire logic [sge_pkg::QIDX_W-1:0]     s_target_qubit,
    input  wire logic [sge_pkg::QIDX_W-1:0]     s_control_qubit,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m00_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m00_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m01_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m01_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m10_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m10_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m11_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m11_im,
    input  wire logic [sge_pkg::RND_W-1:0]      s_random_fraction,
    input  wire logic [sge_pkg::CFG_W-1:0]      active_qubits,
    input  wire logic                           init_busy,
    input  wire logic                           q_full,
    output logic                                q_push,
    output sge_pkg::cmd_t                       q_cmd,
    output logic [NQ_W-1:0]                     n_eff
);
    import sge_pkg::*;

    logic t_bad;
    logic c_bad;

    // clamp the register to 1..MAX_QUBITS
    always_comb begin
        if (active_qubits == '0) begin
            n_eff = NQ_W'(1);
        end else if (int'(active_qubits) > MAX_QUBITS) begin
            n_eff = NQ_W'(MAX_QUBITS);
        end else begin
            n_eff = NQ_W'(active_qubits);
        end
    end

    assign t_bad = int'(s_target_qubit) >= int'(n_eff);
    assign c_bad = int'(s_control_qubit) >= int'(n_eff);

    always_comb begin
        q_cmd.kind    = s_kind;
        q_cmd.target  = s_target_qubit;
        q_cmd.control = s_control_qubit;
        q_cmd.m00_re  = s_m00_re;
        q_cmd.m00_im  = s_m00_im;
        q_cmd.m01_re  = s_m01_re;
        q_cmd.m01_im  = s_m01_im;
        q_cmd.m10_re  = s_m10_re;
        q_cmd.m10_im  = s_m10_im;
        q_cmd.m11_re  = s_m11_re;
        q_cmd.m11_im  = s_m11_im;
        q_cmd.rnd     = s_random_fraction;
        q_cmd.status  = ST_DONE;
        unique case (s_kind)
            KIND_GATE: begin
                if (t_bad) q_cmd.status = ST_RANGE;
            end
            KIND_CNOT: begin
                if (t_bad || c_bad) begin
                    q_cmd.status = ST_RANGE;
                end else if (s_target_qubit == s_control_qubit) begin
                    q_cmd.status = ST_SAME;
                end
            end
            default: q_cmd.status = ST_DONE;
        endcase
    end

    assign s_ready = !q_full && !init_busy;
    assign q_push  = s_valid && s_ready;

endmodule
`default_nettype wire

[hw/rtl/sge_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sge_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sge_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sge_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sge_pkg::cmd_t      head_cmd
);
    import sge_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head_cmd   = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

[hw/rtl/sge_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sge_back: amplitude memory and operation sequencer
// Runs gate, CNOT, measure and clear sweeps over the amplitude memory and
// holds the result register.
// ----------------------------------------------------------------------------
module sge_back #(
    parameter int MAX_QUBITS = sge_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sge_pkg::AMP_WIDTH_DEF,
    parameter int NQ_W       = $clog2(MAX_QUBITS + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire sge_pkg::cmd_t               q_cmd,
    output logic                             q_pop,
    input  wire logic [NQ_W-1:0]             n_eff,
    output logic                             init_busy,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_status,
    output logic [sge_pkg::OUT_W-1:0]        m_outcome
);
    import sge_pkg::*;

    localparam int AW    = AMP_WIDTH;
    localparam int DW    = 2 * AW;
    localparam int MQ    = MAX_QUBITS;
    localparam int IW    = MQ + 1;
    localparam int DEPTH = 1 << MQ;
    localparam int PW    = AW + MAT_W;
    localparam int SW    = PW + 2;
    localparam int QW    = SW - FRAC_BITS;
    localparam int NORM_SHIFT = (AW > 18) ? 2 * (AW - 18) : 0;
    localparam int SUM_W = DW + 1 + MQ;
    localparam longint AMP_MAX_L = (64'sd1 <<< (AW - 1)) - 64'sd1;
    localparam logic signed [QW-1:0] Q_MAX = QW'(AMP_MAX_L);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-AMP_MAX_L - 64'sd1);
    localparam logic [AW-1:0] AMP_ONE = (AW > 17) ? AW'(64'sd65536) : AW'(AMP_MAX_L);
    localparam logic signed [SW-1:0] RND_HALF = SW'(64'sd1 <<< (FRAC_BITS - 1));

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_G_ADV = 4'd2;
    localparam logic [3:0] S_G_RD1 = 4'd3;
    localparam logic [3:0] S_G_RD2 = 4'd4;
    localparam logic [3:0] S_G_MAC = 4'd5;
    localparam logic [3:0] S_C_ADV = 4'd6;
    localparam logic [3:0] S_C_RD1 = 4'd7;
    localparam logic [3:0] S_C_RD2 = 4'd8;
    localparam logic [3:0] S_C_WR1 = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;
    localparam logic [3:0] S_THR   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // amplitude memory, {real, imag} per entry
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [MQ-1:0] rd_addr;
    logic          we;
    logic [MQ-1:0] wa;
    logic [DW-1:0] wd;

    logic [3:0]      state_reg;
    logic            init_reg;
    cmd_t            cmd_reg;
    logic [IW-1:0]   idx_reg;
    logic [2:0]      ph_reg;
    logic [DW-1:0]   a0_reg;
    logic [DW-1:0]   a1_reg;
    logic signed [PW-1:0] p_reg [4];
    logic            p_re_reg;
    logic [AW-1:0]   res_reg [4];
    logic            srch_reg;
    logic            found_reg;
    logic            v1_reg;
    logic            v2_reg;
    logic [MQ-1:0]   ix1_reg;
    logic [MQ-1:0]   ix2_reg;
    logic signed [DW-1:0] sq_re_reg;
    logic signed [DW-1:0] sq_im_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] run_reg;
    logic [SUM_W-1:0] thr_reg;
    logic [4:0]      cnt_reg;
    logic [MQ-1:0]   hit_reg;
    logic            m_valid_reg;
    logic [1:0]      m_status_reg;
    logic [OUT_W-1:0] m_outcome_reg;

    logic [IW-1:0]   dim;
    logic [IW-1:0]   tbit;
    logic [IW-1:0]   cbit;
    logic [MQ-1:0]   idx_a;
    logic [MQ-1:0]   pair_a;
    logic [MQ-1:0]   cpair_a;
    logic            issue;

    logic [1:0]      k;
    logic signed [MAT_W-1:0] ma_re, ma_im, mb_re, mb_im;
    logic signed [AW-1:0]    x0, y0, x1, y1;
    logic signed [SW-1:0]    s_sum;
    logic signed [SW-1:0]    s_rnd;
    logic signed [QW-1:0]    s_q;
    logic [AW-1:0]           s_sat;
    logic [DW:0]             norm;
    logic [SUM_W-1:0]        run_next;
    logic [SUM_W:0]          thr_tmp;

    assign dim     = IW'(1) << n_eff;
    assign tbit    = IW'(1) << cmd_reg.target;
    assign cbit    = IW'(1) << cmd_reg.control;
    assign idx_a   = idx_reg[MQ-1:0];
    assign pair_a  = idx_a | tbit[MQ-1:0];
    assign cpair_a = idx_a | tbit[MQ-1:0];
    assign issue   = (idx_reg != dim) && !found_reg;

    // product operands for output k: bit 1 picks the row, bit 0 real/imag
    assign k = ph_reg[1:0];
    always_comb begin
        ma_re = k[1] ? cmd_reg.m10_re : cmd_reg.m00_re;
        ma_im = k[1] ? cmd_reg.m10_im : cmd_reg.m00_im;
        mb_re = k[1] ? cmd_reg.m11_re : cmd_reg.m01_re;
        mb_im = k[1] ? cmd_reg.m11_im : cmd_reg.m01_im;
        if (!k[0]) begin
            x0 = a0_reg[DW-1:AW];
            y0 = a0_reg[AW-1:0];
            x1 = a1_reg[DW-1:AW];
            y1 = a1_reg[AW-1:0];
        end else begin
            x0 = a0_reg[AW-1:0];
            y0 = a0_reg[DW-1:AW];
            x1 = a1_reg[AW-1:0];
            y1 = a1_reg[DW-1:AW];
        end
    end

    // sum of four products, round half up, saturate
    always_comb begin
        if (p_re_reg) begin
            s_sum = SW'(p_reg[0]) - SW'(p_reg[1]) + SW'(p_reg[2]) - SW'(p_reg[3]);
        end else begin
            s_sum = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]) + SW'(p_reg[3]);
        end
        s_rnd = s_sum + RND_HALF;
        s_q   = s_rnd[SW-1:FRAC_BITS];
        if (s_q > Q_MAX) begin
            s_sat = Q_MAX[AW-1:0];
        end else if (s_q < Q_MIN) begin
            s_sat = Q_MIN[AW-1:0];
        end else begin
            s_sat = s_q[AW-1:0];
        end
    end

    assign norm     = ({1'b0, $unsigned(sq_re_reg)} + {1'b0, $unsigned(sq_im_reg)})
                      >> NORM_SHIFT;
    assign run_next = run_reg + SUM_W'(norm);
    assign thr_tmp  = {1'b0, thr_reg} + (cmd_reg.rnd[cnt_reg] ? {1'b0, sum_reg} : '0);

    // memory port control
    always_comb begin
        rd_addr = idx_a;
        we      = 1'b0;
        wa      = idx_a;
        wd      = '0;
        unique case (state_reg)
            S_CLR: begin
                we = 1'b1;
                wd = {(idx_a == hit_reg) ? AMP_ONE : {AW{1'b0}}, {AW{1'b0}}};
            end
            S_G_RD1: rd_addr = pair_a;
            S_G_MAC: begin
                if (ph_reg == 3'd3) begin
                    we = 1'b1;
                    wd = {res_reg[0], res_reg[1]};
                end else if (ph_reg == 3'd5) begin
                    we = 1'b1;
                    wa = pair_a;
                    wd = {res_reg[2], res_reg[3]};
                end
            end
            S_C_RD1: rd_addr = cpair_a;
            S_C_RD2: begin
                we = 1'b1;
                wd = rd_data_reg;
            end
            S_C_WR1: begin
                we = 1'b1;
                wa = cpair_a;
                wd = a0_reg;
            end
            default: rd_addr = idx_a;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            init_reg    <= 1'b1;
            idx_reg     <= '0;
            hit_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && !m_valid_reg) begin
                        cmd_reg   <= q_cmd;
                        idx_reg   <= '0;
                        hit_reg   <= '0;
                        v1_reg    <= 1'b0;
                        v2_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        srch_reg  <= 1'b0;
                        sum_reg   <= '0;
                        if (q_cmd.status != ST_DONE) begin
                            state_reg <= S_FIN;
                        end else begin
                            unique case (q_cmd.kind)
                                KIND_GATE: state_reg <= S_G_ADV;
                                KIND_CNOT: state_reg <= S_C_ADV;
                                KIND_MEAS: state_reg <= S_SCAN;
                                default:   state_reg <= S_CLR;
                            endcase
                        end
                    end
                end
                S_CLR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IW'(DEPTH - 1)) begin
                        idx_reg   <= '0;
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_FIN;
                    end
                end
                S_G_ADV: begin
                    if (idx_reg == dim) begin
                        state_reg <= S_FIN;
                    end else if ((idx_reg & tbit) != '0) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        state_reg <= S_G_RD1;
                    end
                end
                S_G_RD1: begin
                    a0_reg    <= rd_data_reg;
                    state_reg <= S_G_RD2;
                end
                S_G_RD2: begin
                    a1_reg    <= rd_data_reg;
                    ph_reg    <= 3'd0;
                    state_reg <= S_G_MAC;
                end
                S_G_MAC: begin
                    // products for output ph, sum for output ph-1
                    if (ph_reg < 3'd4) begin
                        p_reg[0] <= ma_re * x0;
                        p_reg[1] <= ma_im * y0;
                        p_reg[2] <= mb_re * x1;
                        p_reg[3] <= mb_im * y1;
                        p_re_reg <= !k[0];
                    end
                    if (ph_reg != 3'd0 && ph_reg < 3'd5) begin
                        res_reg[2'(ph_reg - 3'd1)] <= s_sat;
                    end
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd5) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_G_ADV;
                    end
                end
                S_C_ADV: begin
                    if (idx_reg == dim) begin
                        state_reg <= S_FIN;
                    end else if ((idx_reg & cbit) != '0 && (idx_reg & tbit) == '0) begin
                        state_reg <= S_C_RD1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_C_RD1: begin
                    a0_reg    <= rd_data_reg;
                    state_reg <= S_C_RD2;
                end
                S_C_RD2: state_reg <= S_C_WR1;
                S_C_WR1: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_C_ADV;
                end
                S_SCAN: begin
                    // read, square, accumulate
                    if (issue) idx_reg <= idx_reg + 1'b1;
                    v1_reg    <= issue;
                    ix1_reg   <= idx_a;
                    v2_reg    <= v1_reg;
                    ix2_reg   <= ix1_reg;
                    sq_re_reg <= $signed(rd_data_reg[DW-1:AW]) * $signed(rd_data_reg[DW-1:AW]);
                    sq_im_reg <= $signed(rd_data_reg[AW-1:0]) * $signed(rd_data_reg[AW-1:0]);
                    if (v2_reg) begin
                        if (!srch_reg) begin
                            sum_reg <= sum_reg + SUM_W'(norm);
                        end else if (!found_reg) begin
                            run_reg <= run_next;
                            if (run_next > thr_reg) begin
                                found_reg <= 1'b1;
                                hit_reg   <= ix2_reg;
                            end
                        end
                    end
                    if (!issue && !v1_reg && !v2_reg) begin
                        idx_reg <= '0;
                        if (!srch_reg) begin
                            thr_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_THR;
                        end else begin
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_THR: begin
                    // serial multiply, one bit of the fraction per cycle
                    thr_reg <= thr_tmp[SUM_W:1];
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        srch_reg  <= 1'b1;
                        run_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_FIN: begin
                    m_valid_reg   <= 1'b1;
                    m_status_reg  <= cmd_reg.status;
                    m_outcome_reg <= (cmd_reg.kind == KIND_MEAS && cmd_reg.status == ST_DONE)
                                     ? OUT_W'(hit_reg) : '0;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid && !m_valid_reg;
    assign init_busy = init_reg;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_outcome = m_outcome_reg;

endmodule
`default_nettype wire

[hw/rtl/statevector_gate_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// statevector_gate_engine_unit: fixed-point state-vector gate engine
// Holds 2^n complex amplitudes and applies gates, CNOTs, measurements and
// reinitialization, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one operation per transaction; m_* channel returns
//   status and measured index. active_qubits sits at APB byte address 0.
//   Each transaction runs to completion in the back end; two more can wait
//   in the command queue.
//   Gate and CNOT sweep the 2^n amplitudes in use (n = effective qubits);
//   measure scans them, then again up to the pick, then clears all entries;
//   reinitialize clears all entries; a rejected item runs no sweep.
//   The sweeps are bound by the single read / single write memory port.
//   Reset: a clearing pass over all entries writes |0..0>; s_ready stays low
//   during it. Configuration writes are taken throughout.
//   Receiver stall: the result holds in the output register; the back end
//   waits for it to drain, while the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module statevector_gate_engine_unit #(
    parameter int MAX_QUBITS = sge_pkg::MAX_QUBITS_DEF,
    parameter int AMP_WIDTH  = sge_pkg::AMP_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic [sge_pkg::QIDX_W-1:0]       s_target_qubit,
    input  wire logic [sge_pkg::QIDX_W-1:0]       s_control_qubit,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m00_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m00_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m01_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m01_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m10_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m10_im,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m11_re,
    input  wire logic signed [sge_pkg::MAT_W-1:0] s_m11_im,
    input  wire logic [sge_pkg::RND_W-1:0]        s_random_fraction,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [sge_pkg::OUT_W-1:0]             m_outcome
);
    import sge_pkg::*;

    localparam int NQ_W = $clog2(MAX_QUBITS + 1);

    logic [CFG_W-1:0] aq_reg;
    logic             cfg_wr;
    logic             q_full;
    logic             q_push;
    cmd_t             push_cmd;
    logic             q_pop;
    logic             q_valid;
    cmd_t             head_cmd;
    logic             init_busy;
    logic [NQ_W-1:0]  n_eff;

    // register file: one register at word 0, upper address bit selects nothing
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(aq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aq_reg <= CFG_W'(CFG_RESET);
        end else if (cfg_wr) begin
            aq_reg <= pwdata[CFG_W-1:0];
        end
    end

    // classify and enqueue
    sge_front #(
        .MAX_QUBITS (MAX_QUBITS),
        .NQ_W       (NQ_W)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_target_qubit    (s_target_qubit),
        .s_control_qubit   (s_control_qubit),
        .s_m00_re          (s_m00_re),
        .s_m00_im          (s_m00_im),
        .s_m01_re          (s_m01_re),
        .s_m01_im          (s_m01_im),
        .s_m10_re          (s_m10_re),
        .s_m10_im          (s_m10_im),
        .s_m11_re          (s_m11_re),
        .s_m11_im          (s_m11_im),
        .s_random_fraction (s_random_fraction),
        .active_qubits     (aq_reg),
        .init_busy         (init_busy),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_cmd             (push_cmd),
        .n_eff             (n_eff)
    );

    // hold up to two commands between the sides
    sge_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // execute sweeps over the amplitude memory and drive results
    sge_back #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_WIDTH  (AMP_WIDTH),
        .NQ_W       (NQ_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .n_eff     (n_eff),
        .init_busy (init_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_outcome (m_outcome)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate engine testbench
// Drives gate, CNOT, measure and reinitialize transactions into the state
// vector engine under random sender gaps and receiver stalls, predicts each
// status and measured index with a fixed-point model of the amplitudes, and
// compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted amplitudes and the queue of predicted results.
class sv_scoreboard;
    localparam int DIM = 1024;
    localparam longint AMAX = 131071;
    localparam longint AMIN = -131072;

    longint re[DIM];
    longint im[DIM];
    logic [3:0] qubit_reg;
    logic [1:0] exp_status[$];
    logic [9:0] exp_outcome[$];
    int errors;
    int checked;
    int measured;

    function void clear_state();
        for (int i = 0; i < DIM; i++) begin
            re[i] = 0;
            im[i] = 0;
        end
        re[0] = 65536;
    endfunction

    function void reset_all();
        qubit_reg = 4'd10;
        clear_state();
        exp_status.delete();
        exp_outcome.delete();
        errors = 0;
        checked = 0;
        measured = 0;
    endfunction

    function int live_qubits();
        if (qubit_reg == 0) return 1;
        if (qubit_reg > 10) return 10;
        return qubit_reg;
    endfunction

    function longint round_sat(longint s);
        longint q;
        q = (s + 32768) >>> 16;
        if (q > AMAX) return AMAX;
        if (q < AMIN) return AMIN;
        return q;
    endfunction

    function void gate(int t, longint m[8]);
        int dim;
        int b;
        longint ar, ai, br, bi;
        dim = 1 << live_qubits();
        b = 1 << t;
        for (int i = 0; i < dim; i++) begin
            if ((i & b) == 0) begin
                ar = re[i]; ai = im[i]; br = re[i | b]; bi = im[i | b];
                re[i] = round_sat(m[0]*ar - m[1]*ai + m[2]*br - m[3]*bi);
                im[i] = round_sat(m[0]*ai + m[1]*ar + m[2]*bi + m[3]*br);
                re[i | b] = round_sat(m[4]*ar - m[5]*ai + m[6]*br - m[7]*bi);
                im[i | b] = round_sat(m[4]*ai + m[5]*ar + m[6]*bi + m[7]*br);
            end
        end
    endfunction

    function void cnot(int c, int t);
        int dim;
        longint tr, ti;
        dim = 1 << live_qubits();
        for (int i = 0; i < dim; i++) begin
            if (((i >> c) & 1) == 1 && ((i >> t) & 1) == 0) begin
                tr = re[i]; ti = im[i];
                re[i] = re[i | (1 << t)]; im[i] = im[i | (1 << t)];
                re[i | (1 << t)] = tr; im[i | (1 << t)] = ti;
            end
        end
    endfunction

    function int measure(logic [31:0] r);
        int dim;
        int pick;
        logic [63:0] total, thr, run;
        logic [127:0] prod;
        dim = 1 << live_qubits();
        total = 0;
        run = 0;
        pick = 0;
        for (int i = 0; i < dim; i++) total += re[i]*re[i] + im[i]*im[i];
        prod = total * r;
        thr = prod >> 32;
        for (int i = 0; i < dim; i++) begin
            run += re[i]*re[i] + im[i]*im[i];
            if (run > thr) begin
                pick = i;
                break;
            end
        end
        clear_state();
        if (pick != 0) begin
            re[0] = 0;
            re[pick] = 65536;
        end
        return pick;
    endfunction

    // Note an accepted input transaction and queue its predicted result.
    function void note_input(logic [1:0] kind, logic [3:0] t, logic [3:0] c,
                             longint m[8], logic [31:0] r);
        logic [1:0] st;
        int oc;
        int n;
        st = sge_pkg::ST_DONE;
        oc = 0;
        n = live_qubits();
        case (kind)
            sge_pkg::KIND_GATE: begin
                if (t >= n) st = sge_pkg::ST_RANGE;
                else gate(t, m);
            end
            sge_pkg::KIND_CNOT: begin
                if (c >= n || t >= n) st = sge_pkg::ST_RANGE;
                else if (c == t) st = sge_pkg::ST_SAME;
                else cnot(c, t);
            end
            sge_pkg::KIND_MEAS: begin
                oc = measure(r);
                measured++;
            end
            default: clear_state();
        endcase
        exp_status = {exp_status, st};
        exp_outcome = {exp_outcome, oc[9:0]};
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [1:0] st, logic [9:0] oc);
        checked++;
        if (exp_status.size() == 0) begin
            $display("%0t: unexpected result status=%0d outcome=%0d", $time, st, oc);
            errors++;
            return;
        end
        if (st !== exp_status[0]) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_status[0], st);
            errors++;
        end
        if (oc !== exp_outcome[0]) begin
            $display("%0t: outcome expected %0d actual %0d", $time, exp_outcome[0], oc);
            errors++;
        end
        void'(exp_status.pop_front());
        void'(exp_outcome.pop_front());
    endfunction
endclass

module tb_top;
    import sge_pkg::*;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [1:0] s_kind;
    logic [3:0] s_target_qubit, s_control_qubit;
    logic signed [17:0] s_mat[8];
    logic [31:0] s_random_fraction;
    logic m_valid, m_ready;
    logic [1:0] m_status;
    logic [9:0] m_outcome;

    sv_scoreboard sb;
    bit hold_off;       // long receiver stall requested by the stimulus
    int sent;

    statevector_gate_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_target_qubit(s_target_qubit), .s_control_qubit(s_control_qubit),
        .s_m00_re(s_mat[0]), .s_m00_im(s_mat[1]), .s_m01_re(s_mat[2]),
        .s_m01_im(s_mat[3]), .s_m10_re(s_mat[4]), .s_m10_im(s_mat[5]),
        .s_m11_re(s_mat[6]), .s_m11_im(s_mat[7]),
        .s_random_fraction(s_random_fraction),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_outcome(m_outcome)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: far above the slowest correct run (about 300 items plus stalls).
    initial begin
        #80ms;
        $display("statevector_gate_engine_unit test failed");
        $finish;
    end

    // Write the qubit-count register through a setup and an access cycle.
    task automatic write_qubits(input logic [3:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {28'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.qubit_reg = value;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one transaction, hold it until accepted, then predict its result.
    task automatic send_op(input logic [1:0] kind, input logic [3:0] t, input logic [3:0] c,
                           input longint m[8], input logic [31:0] r);
        s_valid <= 1'b1;
        s_kind <= kind; s_target_qubit <= t; s_control_qubit <= c;
        for (int k = 0; k < 8; k++) s_mat[k] <= m[k][17:0];
        s_random_fraction <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, t, c, m, r);
        sent++;
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Wait for every predicted result, then let the back end settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.exp_status.size() != 0) @(negedge aclk);
        repeat (2100) @(negedge aclk);
    endtask

    function automatic void rand_matrix(output longint m[8], input int style);
        for (int k = 0; k < 8; k++) begin
            case (style)
                0: m[k] = $signed(18'($urandom));
                1: m[k] = longint'($urandom_range(0, 46341)) - 23170;
                default: m[k] = 0;
            endcase
        end
        if (style == 2) begin
            // Unitary-like: Hadamard, Pauli X, or phase, keeping norms alive.
            case ($urandom_range(0, 2))
                0: begin m[0] = 46341; m[2] = 46341; m[4] = 46341; m[6] = -46341; end
                1: begin m[2] = 65536; m[4] = 65536; end
                default: begin m[0] = 65536; m[7] = 46341; m[6] = 46341; end
            endcase
        end
    endfunction

    // Receiver: random stall pattern, plus a long hold-off on request.
    initial begin
        int pat;
        m_ready = 1'b0;
        pat = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (20000) @(negedge aclk);
                hold_off = 1'b0;
            end
            pat++;
            if ((pat / 200) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_status, m_outcome);
    end

    initial begin
        longint m[8];
        longint eye[8];
        int burst;
        sb = new();
        sb.reset_all();
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_kind = KIND_GATE; s_target_qubit = 0; s_control_qubit = 0;
        for (int k = 0; k < 8; k++) s_mat[k] = 0;
        s_random_fraction = 0;
        hold_off = 0; sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        eye = '{65536, 0, 0, 0, 0, 0, 65536, 0};
        // Directed: extremes, every kind, every rejection case.
        write_qubits(4'd3);
        rand_matrix(m, 2);
        m = '{46341, 0, 46341, 0, 46341, 0, -46341, 0};
        send_op(KIND_GATE, 4'd0, 4'd0, m, 32'd0);
        send_op(KIND_CNOT, 4'd1, 4'd0, m, 32'd0);
        send_op(KIND_CNOT, 4'd2, 4'd2, m, 32'd0);
        send_op(KIND_CNOT, 4'd15, 4'd15, m, 32'd0);
        send_op(KIND_CNOT, 4'd0, 4'd3, m, 32'd0);
        send_op(KIND_GATE, 4'd3, 4'd0, m, 32'd0);
        send_op(KIND_GATE, 4'd15, 4'd0, m, 32'd0);
        send_op(KIND_MEAS, 4'd0, 4'd0, m, 32'hFFFF_FFFF);
        send_op(KIND_GATE, 4'd2, 4'd0, '{131071, 131071, 131071, 131071,
                -131072, -131072, -131072, -131072}, 32'd0);
        send_op(KIND_GATE, 4'd1, 4'd0, '{-131072, -131072, -131072, -131072,
                131071, 131071, 131071, 131071}, 32'd0);
        send_op(KIND_MEAS, 4'd0, 4'd0, eye, 32'd0);
        send_op(KIND_GATE, 4'd0, 4'd0, '{0, 0, 0, 0, 0, 0, 0, 0}, 32'd0);
        send_op(KIND_MEAS, 4'd0, 4'd0, eye, 32'h8000_0000);   // all-zero vector
        send_op(KIND_INIT, 4'hF, 4'hF, eye, 32'hFFFF_FFFF);
        drain();
        write_qubits(4'd0);  // acts as one qubit
        send_op(KIND_GATE, 4'd1, 4'd0, eye, 32'd0);
        send_op(KIND_GATE, 4'd0, 4'd0, m, 32'd0);
        send_op(KIND_MEAS, 4'd0, 4'd0, m, 32'h7FFF_FFFF);
        drain();
        write_qubits(4'd15); // acts as ten qubits
        send_op(KIND_GATE, 4'd9, 4'd0, m, 32'd0);
        send_op(KIND_CNOT, 4'd0, 4'd9, m, 32'd0);
        send_op(KIND_MEAS, 4'd0, 4'd0, m, 32'hC000_0000);
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_qubits(4'd1);
                1: write_qubits(4'd4);
                2: write_qubits(4'd2);
                3: write_qubits(4'd5);
                4: write_qubits(4'd10);
                default: write_qubits(4'($urandom_range(0, 15)));
            endcase
            for (int it = 0; it < 45; it++) begin
                logic [1:0] kind;
                logic [3:0] t, c;
                int n;
                n = sb.live_qubits();
                if (ph == 4 && it == 3) hold_off = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    kind = 2'($urandom); t = 4'($urandom); c = 4'($urandom);
                    rand_matrix(m, 0);
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: kind = KIND_GATE;
                        4, 5, 6: kind = KIND_CNOT;
                        7, 8: kind = KIND_MEAS;
                        default: kind = KIND_INIT;
                    endcase
                    t = 4'($urandom_range(0, n - 1));
                    c = 4'($urandom_range(0, n - 1));
                    rand_matrix(m, $urandom_range(0, 3) == 0 ? 1 : 2);
                end
                send_op(kind, t, c, m, $urandom);
                burst = $urandom_range(0, 3);
                if (burst == 0) idle_sender($urandom_range(1, 40));
            end
            drain();
        end

        $display("Covered %0d transactions, %0d measurements, %0d results checked.",
                 sent, sb.measured, sb.checked);
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("statevector_gate_engine_unit test passed");
        else
            $display("statevector_gate_engine_unit test failed");
        $finish;
    end
endmodule
